>>> hw/rtl/fixed_point_alu_q32_macros.svh
// Assertion macros shared by the RTL files.
`ifndef FIXED_POINT_ALU_Q32_MACROS_SVH
`define FIXED_POINT_ALU_Q32_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned WideW      = 64;
  localparam int unsigned SqrtRounds = 10;
  localparam int unsigned RoundW     = 4;
  localparam int unsigned DivCntW    = 7;

  localparam logic [DataW-1:0] One = DataW'(1) << FracBits;
  localparam logic [DataW-1:0] Eps = DataW'(1) << (FracBits - 4);

  typedef enum logic [2:0] {
    OpAdd    = 3'd0,
    OpSub    = 3'd1,
    OpMul    = 3'd2,
    OpDiv    = 3'd3,
    OpSquare = 3'd4,
    OpAbs    = 3'd5,
    OpSqrt   = 3'd6,
    OpNone   = 3'd7
  } op_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/fpa_if.sv
interface fpa_in_if;
  import fpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       op;
  logic signed [DataW-1:0] a;
  logic signed [DataW-1:0] b;
  modport source (output valid, output op, output a, output b, input ready);
  modport sink   (input valid, input op, input a, input b, output ready);
endinterface

interface fpa_out_if;
  import fpa_pkg::*;
  logic             valid;
  logic             ready;
  logic signed [DataW-1:0] result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

>>> hw/rtl/fpa_divider.sv
`include "fixed_point_alu_q32_macros.svh"
// Radix-2 restoring divider: (dividend << FracBits) / divisor, toward zero.
module fpa_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpa_pkg::div_req_t  req_i,
  output fpa_pkg::div_rsp_t  rsp_o
);
  import fpa_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [WideW-1:0]   num_q, num_d;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   den_q, den_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [WideW-1:0]   num_abs;
  logic [DataW:0]     trial;
  logic [DataW:0]     rem_sh;
  logic [WideW-1:0]   q_mag;

  always_comb begin
    num_abs = WideW'($signed(req_i.dividend)) << FracBits;
    if (req_i.dividend[DataW-1]) num_abs = WideW'(0) - num_abs;
    rem_sh  = {rem_q, num_q[WideW-1]};
    trial   = rem_sh - {1'b0, den_q};
    q_mag   = {num_q[WideW-2:0], ~trial[DataW]};
    busy_d = busy_q; done_d = 1'b0; cnt_d = cnt_q; neg_d = neg_q;
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = req_i.dividend[DataW-1] ^ req_i.divisor[DataW-1];
      num_d  = num_abs;
      rem_d  = '0;
      den_d  = req_i.divisor[DataW-1] ? DataW'(0) - req_i.divisor : req_i.divisor;
      if (req_i.divisor == '0) begin
        busy_d = 1'b0; done_d = 1'b1; quo_d = '0;
      end
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it always fits in DataW bits.
      rem_d = trial[DataW] ? rem_sh[DataW-1:0] : trial[DataW-1:0];
      num_d = q_mag;
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(WideW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
        quo_d  = neg_q ? DataW'(0) - q_mag[DataW-1:0] : q_mag[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `FPA_ASSERT_IMP(a_no_done_busy, clk_i, rst_ni, done_q, !busy_q, "done while busy")
  `FPA_ASSERT_IMP(a_cnt_idle, clk_i, rst_ni, !busy_q, cnt_q <= DivCntW'(WideW), "count")
  `FPA_ASSERT_NEXT(a_zero_div, clk_i, rst_ni, req_i.start && req_i.divisor == '0,
    done_q && quo_q == '0, "divide by zero")
endmodule

>>> hw/rtl/fixed_point_alu_q32.sv
// Path from acceptance to result word: add, sub, abs and unused codes write the result register
// directly; multiply and square pass the product register; divide runs a 64-step radix-2 loop,
// cut short on a zero divisor. Square root takes up to 10 rounds, each one divider run.
// Throughput: one word at a time; the next word is taken the cycle after the result leaves.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle with no result held.
`include "fixed_point_alu_q32_macros.svh"
module fixed_point_alu_q32 (
  input  logic clk_i,
  input  logic rst_ni,
  fpa_in_if.sink    in_i,
  fpa_out_if.source out_o
);
  import fpa_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StMul, StDivWait, StSqChk, StSqDiv, StOut
  } state_e;

  state_e             state_q;
  logic [2:0]         op_q;
  logic [DataW-1:0]   a_q, b_q, x_q, y_q, res_q;
  logic [RoundW-1:0]  rnd_q;
  logic [WideW-1:0]   prod_q;
  logic               start_q;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [DataW-1:0]   diff, adiff, xy_sum, half;
  logic [WideW-1:0]   prod_sh;
  logic [WideW-1:0]   mul_full;

  // The divider is shared by divide and every square-root round.
  fpa_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    diff    = x_q - y_q;
    adiff   = diff[DataW-1] ? DataW'(0) - diff : diff;
    xy_sum  = x_q + y_q;
    // Halving toward zero: add one to negative sums before the shift.
    half    = DataW'(($signed(xy_sum) + $signed(DataW'(xy_sum[DataW-1]))) >>> 1);
    prod_sh = WideW'($signed(prod_q) >>> FracBits);
    // Both operands are signed, so they are sign-extended to the full product width.
    mul_full = $signed(in_i.a) * $signed((op_e'(in_i.op) == OpSquare) ? in_i.a : in_i.b);
    dreq.start    = start_q;
    dreq.dividend = a_q;
    dreq.divisor  = (op_q == OpDiv) ? b_q : x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            op_q <= in_i.op; a_q <= in_i.a; b_q <= in_i.b;
            x_q <= in_i.a; y_q <= One; rnd_q <= '0;
            unique case (op_e'(in_i.op))
              OpAdd: begin res_q <= in_i.a + in_i.b; state_q <= StOut; end
              OpSub: begin res_q <= in_i.a - in_i.b; state_q <= StOut; end
              OpMul: begin
                prod_q <= mul_full; state_q <= StMul;
              end
              OpSquare: begin
                prod_q <= mul_full; state_q <= StMul;
              end
              OpDiv: begin start_q <= 1'b1; state_q <= StDivWait; end
              OpAbs: begin
                res_q <= in_i.a[DataW-1] ? DataW'(0) - in_i.a : in_i.a; state_q <= StOut;
              end
              OpSqrt: begin
                if ($signed(in_i.a) <= 0) begin res_q <= '0; state_q <= StOut; end
                else state_q <= StSqChk;
              end
              default: begin res_q <= '0; state_q <= StOut; end
            endcase
          end
        end
        StMul: begin res_q <= prod_sh[DataW-1:0]; state_q <= StOut; end
        StDivWait: begin
          if (drsp.done) begin res_q <= drsp.quotient; state_q <= StOut; end
        end
        StSqChk: begin
          // The most negative difference wraps and counts as not above eps.
          if ($signed(adiff) > $signed(Eps) && rnd_q < RoundW'(SqrtRounds)) begin
            x_q <= half; rnd_q <= rnd_q + RoundW'(1);
            start_q <= 1'b1; state_q <= StSqDiv;
          end else begin
            res_q <= x_q; state_q <= StOut;
          end
        end
        StSqDiv: begin
          if (drsp.done) begin y_q <= drsp.quotient; state_q <= StSqChk; end
        end
        StOut: begin
          if (out_o.ready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_i.ready   = (state_q == StIdle);
  assign out_o.valid  = (state_q == StOut);
  assign out_o.result = res_q;

  `FPA_ASSERT_IMP(a_excl, clk_i, rst_ni, out_o.valid, !in_i.ready, "ready during output")
  `FPA_ASSERT_IMP(a_rounds, clk_i, rst_ni, state_q == StSqChk, rnd_q <= RoundW'(SqrtRounds),
    "too many rounds")
  `FPA_ASSERT_NEXT(a_start, clk_i, rst_ni, start_q, drsp.busy || drsp.done, "divider idle")
endmodule

>>> tb/sv/tb_fixed_point_alu_q32.sv
module tb_fixed_point_alu_q32;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  // Scoreboard: works out the expected result word for each accepted input word
  // and compares the result words, oldest first.
  class alu_scoreboard;
    logic [DataW-1:0] pending_q[$];
    int unsigned      n_errors;
    int unsigned      n_checked;

    function automatic logic [DataW-1:0] fx_mul(logic [DataW-1:0] x, logic [DataW-1:0] y);
      logic signed [WideW-1:0] prod;
      prod = $signed({{DataW{x[DataW-1]}}, x}) * $signed({{DataW{y[DataW-1]}}, y});
      prod = prod >>> FracBits;
      return prod[DataW-1:0];
    endfunction

    function automatic logic [DataW-1:0] fx_div(logic [DataW-1:0] x, logic [DataW-1:0] y);
      logic signed [WideW-1:0] num;
      logic signed [WideW-1:0] den;
      logic signed [WideW-1:0] quo;
      if (y == '0) return '0;
      num = $signed({{DataW{x[DataW-1]}}, x}) <<< FracBits;
      den = $signed({{DataW{y[DataW-1]}}, y});
      quo = num / den;
      return quo[DataW-1:0];
    endfunction

    function automatic logic [DataW-1:0] fx_abs(logic [DataW-1:0] x);
      return x[DataW-1] ? DataW'(0) - x : x;
    endfunction

    // Heron iteration, every intermediate wrapped to 32 bits.
    function automatic logic [DataW-1:0] fx_sqrt(logic [DataW-1:0] x0);
      logic [DataW-1:0] x;
      logic [DataW-1:0] y;
      logic [DataW-1:0] s;
      int               rounds;
      x = x0;
      y = One;
      rounds = 0;
      if ($signed(x0) <= 0) return '0;
      while ($signed(fx_abs(x - y)) > $signed(Eps) && rounds < SqrtRounds) begin
        rounds++;
        s = x + y;
        x = DataW'($signed(s) / 2);
        y = fx_div(x0, x);
      end
      return x;
    endfunction

    function void note_operands(logic [2:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b);
      logic [DataW-1:0] r;
      case (op_e'(op))
        OpAdd:    r = a + b;
        OpSub:    r = a - b;
        OpMul:    r = fx_mul(a, b);
        OpDiv:    r = fx_div(a, b);
        OpSquare: r = fx_mul(a, a);
        OpAbs:    r = fx_abs(a);
        OpSqrt:   r = fx_sqrt(a);
        default:  r = '0;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [DataW-1:0] got);
      logic [DataW-1:0] want;
      n_checked++;
      if (pending_q.size() == 0) begin
        $error("result word %h arrived with nothing expected", got);
        n_errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $error("field result: expected %h, actual %h", want, got);
        n_errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  fpa_in_if  in_if ();
  fpa_out_if out_if ();

  fixed_point_alu_q32 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  alu_scoreboard sb;
  bit            quiet;     // set for the closing stretch: no idling on either side
  int unsigned   n_sent;
  int unsigned   n_sqrt;
  longint        cycles = 0;

  localparam longint CycleLimit = 4_000_000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. The slowest correct run is roughly 850 square roots, each at its longest,
  // plus receiver stalls, so the limit sits several times above that.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[fixed_point_alu_q32] ERROR");
      $finish;
    end
  end

  // Monitor: both channels are sampled at the rising edge, where the handshake counts.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.note_operands(in_if.op, in_if.a, in_if.b);
      n_sent++;
      if (op_e'(in_if.op) == OpSqrt) n_sqrt++;
    end
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.result);
  end

  // Receiver: ready drops in bursts of random length, except near the end.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 15);
        out_if.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offers one operand word and holds it until it is taken.
  task automatic send_word(logic [2:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.a     <= a;
    in_if.b     <= b;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Operand picked to reach both extremes, small magnitudes and whole numbers.
  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return DataW'($signed($urandom_range(0, 8 << FracBits)) - (4 << FracBits));
      2: return DataW'($urandom_range(0, 255)) << FracBits;
      3: return {1'b1, 31'($urandom())};
      4: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom_range(0, 1 << FracBits);
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    sb = new();
    quiet = 1'b0;
    n_sent = 0;
    n_sqrt = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op    = OpAdd;
    in_if.a     = '0;
    in_if.b     = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: extremes, every code, the divide and square-root corner cases.
    send_word(OpAdd,    32'h7fff_ffff, 32'h0000_0001);
    send_word(OpSub,    32'h8000_0000, 32'h0000_0001);
    send_word(OpMul,    32'h8000_0000, 32'h8000_0000);
    send_word(OpMul,    32'hffff_ffff, 32'h7fff_ffff);
    send_word(OpDiv,    32'h0003_0000, 32'h0000_0000);
    send_word(OpDiv,    32'h8000_0000, 32'hffff_ffff);
    send_word(OpDiv,    32'hfffd_0000, 32'h0002_0000);
    send_word(OpSquare, 32'h8000_0000, 32'h1234_5678);
    send_word(OpAbs,    32'h8000_0000, 32'h0);
    send_word(OpAbs,    32'hffff_0000, 32'hffff_ffff);
    send_word(OpSqrt,   32'h0000_0000, 32'h0);
    send_word(OpSqrt,   32'h8000_0000, 32'h0);
    send_word(OpSqrt,   32'h0004_0000, 32'h0);
    send_word(OpSqrt,   32'h0001_0000, 32'h0);
    send_word(OpSqrt,   32'h0000_0001, 32'h0);
    send_word(OpSqrt,   32'h7fff_ffff, 32'hffff_ffff);
    send_word(OpNone,   32'hdead_beef, 32'hffff_ffff);

    // The sender waits here until every expected word is back.
    drain();

    repeat (850) begin
      if (n_sent > 700) quiet = 1'b1;
      op = 3'($urandom_range(0, 7));
      send_word(op, pick_operand(), pick_operand());
    end
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d operand words (%0d square roots) and %0d result words.",
             n_sent, n_sqrt, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("[fixed_point_alu_q32] OK");
    end else begin
      $display("[fixed_point_alu_q32] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_if.sv
hw/rtl/fpa_divider.sv
hw/rtl/fixed_point_alu_q32.sv
tb/sv/tb_fixed_point_alu_q32.sv
